@@ sv/c2p_pkg.sv @@
package c2p_pkg;

  // Default widths and iteration count of the converter.
  localparam int DataWidthDef  = 16;
  localparam int AngleStepsDef = 16;
  localparam int PhaseWidth    = 16;

  // Fraction bits appended below the input LSB for the rotations.
  localparam int GuardBits = 8;

  // Angle accumulator: 32 bits, pi is 2^31.
  localparam int              AngleWidth = 32;
  localparam logic [31:0]     AnglePi    = 32'h8000_0000;
  localparam logic [31:0]     PhaseRound = 32'h0000_8000;

  // CORDIC gain compensation, round(0.60725293500888 * 2^32).
  localparam logic [31:0] GainQ32 = 32'h9B74_EDA8;

  // The magnitude product is split at this bit.
  localparam int GainSplit = 21;
  // Final magnitude shift is GainShift, rounded at half an LSB.
  localparam int GainShift = 11 + GuardBits;

  localparam int TableLen = 32;

  // atan(2^-i) in the accumulator's units.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      5'd24:   val = 32'h0000_0029;
      5'd25:   val = 32'h0000_0014;
      5'd26:   val = 32'h0000_000A;
      5'd27:   val = 32'h0000_0005;
      5'd28:   val = 32'h0000_0003;
      5'd29:   val = 32'h0000_0001;
      5'd30:   val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

@@ sv/c2p_if.sv @@
interface c2p_cplx_if #(
  parameter int DataWidth = c2p_pkg::DataWidthDef
);
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] real_part;
  logic signed [DataWidth-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface c2p_polar_if #(
  parameter int DataWidth = c2p_pkg::DataWidthDef
);
  import c2p_pkg::*;

  logic                         valid;
  logic                         ready;
  logic        [DataWidth-1:0]  magnitude;
  logic signed [PhaseWidth-1:0] phase;

  modport source (output valid, output magnitude, output phase, input ready);
  modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

@@ sv/c2p_stage.sv @@
module c2p_stage #(
  parameter int Width = 28,
  parameter int Step  = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [Width-1:0]        x_i,
  input  logic signed [Width-1:0]        y_i,
  input  logic [c2p_pkg::AngleWidth-1:0] z_i,
  input  logic                           zero_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [Width-1:0]        x_o,
  output logic signed [Width-1:0]        y_o,
  output logic [c2p_pkg::AngleWidth-1:0] z_o,
  output logic                           zero_o
);
  import c2p_pkg::*;

  localparam logic [AngleWidth-1:0] StepAngle = atan_entry(5'(Step));

  logic                    valid_q;
  logic                    adv;
  logic signed [Width-1:0] xs, ys;
  logic signed [Width-1:0] x_d, y_d, x_q, y_q;
  logic [AngleWidth-1:0]   z_d, z_q;
  logic                    zero_q;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  assign xs = x_i >>> Step;
  assign ys = y_i >>> Step;

  // Rotate toward the positive real axis; a non-negative y turns clockwise.
  always_comb begin
    if (!y_i[Width-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + StepAngle;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - StepAngle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign zero_o  = zero_q;

endmodule

@@ sv/cartesian_to_polar.sv @@
// Cartesian to polar converter for a stream of complex samples.
// The in_i channel carries one signed sample (real_part, imag_part) per
// transfer; out_o returns its magnitude, sqrt(re^2 + im^2) on the input
// scale, and its phase as a 16-bit binary angle where 32768 counts are pi
// (plus pi wraps to -32768). A zero sample gives magnitude 0 and phase 0.
// The datapath is a CORDIC in vectoring mode: one register stage folds the
// sample into the right half plane, AngleSteps stages each perform one
// micro-rotation, one stage forms the gain-compensation products and the
// last stage rounds and holds the result for the receiver.
// Throughput is one sample per cycle while the receiver takes every result.
// Every stage carries its own valid bit and moves only when the stage after
// it is empty or moving, so a stalled receiver holds the result steady and
// the stages behind it keep filling their bubbles before in_i.ready drops.
// Reset clears all valid bits; no sample is held across reset and there is
// nothing else to clear.
module cartesian_to_polar #(
  parameter int DataWidth  = c2p_pkg::DataWidthDef,
  parameter int AngleSteps = c2p_pkg::AngleStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  c2p_cplx_if.sink    in_i,
  c2p_polar_if.source out_o
);
  import c2p_pkg::*;

  // Rotation width: input, guard bits, the sign of a negated minimum
  // value and headroom for the CORDIC gain of about 1.65 times sqrt(2).
  localparam int Width = DataWidth + GuardBits + 4;
  // The magnitude operand is split at GainSplit; keep at least one high bit.
  localparam int UWidth  = (Width - 1 > GainSplit + 1) ? Width - 1 : GainSplit + 1;
  localparam int HiWidth = UWidth - GainSplit;
  localparam int LoProd  = GainSplit + 32;
  localparam int SumWidth = HiWidth + 33;
  localparam logic [SumWidth-1:0] RoundHalf = SumWidth'(1) << (GainShift - 1);

  // Per-stage signals; index 0 is the input stage, index k holds the vector
  // after k micro-rotations.
  logic                    vld_s  [AngleSteps+1];
  logic                    rdy_s  [AngleSteps+2];
  logic signed [Width-1:0] x_s    [AngleSteps+1];
  logic signed [Width-1:0] y_s    [AngleSteps+1];
  logic [AngleWidth-1:0]   z_s    [AngleSteps+1];
  logic                    zero_s [AngleSteps+1];

  // ---------------------------------------------------------------------
  // Input stage: sign extension, half-plane fold and guard-bit shift.
  // ---------------------------------------------------------------------
  logic                    in_adv;
  logic signed [Width-1:0] xe, ye, xf, yf;
  logic [AngleWidth-1:0]   z0_d;
  logic                    zero_d;
  logic                    vld0_q;
  logic signed [Width-1:0] x0_q, y0_q;
  logic [AngleWidth-1:0]   z0_q;
  logic                    zero0_q;

  assign in_adv     = !vld0_q || rdy_s[1];
  assign in_i.ready = in_adv;

  assign xe     = Width'(in_i.real_part);
  assign ye     = Width'(in_i.imag_part);
  assign zero_d = (in_i.real_part == '0) && (in_i.imag_part == '0);

  // A sample in the left half plane is turned by pi first, so the
  // rotations only ever cover plus or minus about 100 degrees.
  always_comb begin
    if (in_i.real_part < 0) begin
      xf   = -xe;
      yf   = -ye;
      z0_d = AnglePi;
    end else begin
      xf   = xe;
      yf   = ye;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (in_adv) begin
      vld0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      x0_q    <= xf <<< GuardBits;
      y0_q    <= yf <<< GuardBits;
      z0_q    <= z0_d;
      zero0_q <= zero_d;
    end
  end

  assign rdy_s[0]  = in_adv;
  assign vld_s[0]  = vld0_q;
  assign x_s[0]    = x0_q;
  assign y_s[0]    = y0_q;
  assign z_s[0]    = z0_q;
  assign zero_s[0] = zero0_q;

  // ---------------------------------------------------------------------
  // Micro-rotation stages, one table angle each.
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= AngleSteps; k++) begin : g_rot
    c2p_stage #(
      .Width (Width),
      .Step  (k - 1)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[k-1]),
      .ready_o (rdy_s[k]),
      .x_i     (x_s[k-1]),
      .y_i     (y_s[k-1]),
      .z_i     (z_s[k-1]),
      .zero_i  (zero_s[k-1]),
      .valid_o (vld_s[k]),
      .ready_i (rdy_s[k+1]),
      .x_o     (x_s[k]),
      .y_o     (y_s[k]),
      .z_o     (z_s[k]),
      .zero_o  (zero_s[k])
    );
  end

  // ---------------------------------------------------------------------
  // Gain stage: x * K as two partial products, phase rounding.
  // ---------------------------------------------------------------------
  logic signed [Width-1:0]  x_fin;
  logic [UWidth-1:0]        ux;
  logic [HiWidth+31:0]      prod_hi_d, prod_hi_q;
  logic [LoProd-1:0]        prod_lo;
  logic [31:0]              lo_sh_q;
  logic [AngleWidth-1:0]    z_rnd;
  logic [PhaseWidth-1:0]    ph_d, ph_q;
  logic                     zero_m_q;
  logic                     mul_vld_q;
  logic                     mul_adv;
  logic                     out_adv;

  assign x_fin = x_s[AngleSteps];
  // A negative final x would read as zero; the fold keeps it non-negative.
  assign ux    = x_fin[Width-1] ? '0 : UWidth'(x_fin[Width-2:0]);

  assign prod_hi_d = (HiWidth+32)'(ux[UWidth-1:GainSplit]) * (HiWidth+32)'(GainQ32);
  assign prod_lo   = LoProd'(ux[GainSplit-1:0]) * LoProd'(GainQ32);

  assign z_rnd = z_s[AngleSteps] + PhaseRound;
  assign ph_d  = zero_s[AngleSteps] ? '0 : z_rnd[AngleWidth-1 -: PhaseWidth];

  assign mul_adv          = !mul_vld_q || out_adv;
  assign rdy_s[AngleSteps+1] = mul_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (mul_adv) begin
      mul_vld_q <= vld_s[AngleSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_adv && vld_s[AngleSteps]) begin
      prod_hi_q <= prod_hi_d;
      lo_sh_q   <= prod_lo[LoProd-1:GainSplit];
      ph_q      <= ph_d;
      zero_m_q  <= zero_s[AngleSteps];
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: sum, round, saturate and hold for the receiver.
  // ---------------------------------------------------------------------
  logic [SumWidth-1:0]          mag_sum;
  logic [SumWidth-GainShift-1:0] mag_full;
  logic [DataWidth-1:0]         mag_d, mag_q;
  logic signed [PhaseWidth-1:0] phase_q;
  logic                         out_vld_q;

  assign mag_sum  = SumWidth'(prod_hi_q) + SumWidth'(lo_sh_q) + RoundHalf;
  assign mag_full = mag_sum[SumWidth-1:GainShift];

  always_comb begin
    if (zero_m_q) begin
      mag_d = '0;
    end else if (|mag_full[SumWidth-GainShift-1:DataWidth]) begin
      mag_d = '1;
    end else begin
      mag_d = mag_full[DataWidth-1:0];
    end
  end

  assign out_adv = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && mul_vld_q) begin
      mag_q   <= mag_d;
      phase_q <= ph_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.magnitude = mag_q;
  assign out_o.phase     = phase_q;

endmodule

@@ sv/c2p_checker.sv @@
module c2p_checker #(
  parameter int DataWidth = c2p_pkg::DataWidthDef
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [DataWidth-1:0]               out_magnitude_i,
  input logic signed [c2p_pkg::PhaseWidth-1:0] out_phase_i
);
  import c2p_pkg::*;

  // Nothing can come out in the first cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // A receiver that takes results never throttles the input.
  a_full_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is ready");

  // The input only stalls when the pipeline is backed up at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without an output stall");

  // A held result keeps its value until transferred.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_magnitude_i) && $stable(out_phase_i)))
    else $error("result changed while stalled");

endmodule

bind cartesian_to_polar c2p_checker #(
  .DataWidth (DataWidth)
) u_c2p_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_magnitude_i (out_o.magnitude),
  .out_phase_i     (out_o.phase)
);

@@ test/testbench.sv @@
// Self-checking testbench for the cartesian_to_polar CORDIC converter.
//
// A driver and a monitor, both clocked always blocks, sit on the two
// channels. The driver takes samples from a queue that the stimulus block
// fills before reset is released. For every sample that it transfers, it
// computes the expected polar result with a local bit-exact model of the
// vectoring CORDIC and appends it to the queue of outstanding results. The
// monitor compares every result transfer, field by field, with the oldest
// outstanding result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c2p_pkg::*;

  localparam int Width = DataWidthDef;
  localparam int Steps = 16;

  // Fraction bits added below the sample LSB before the rotations.
  localparam int FracBits = 8;

  // Arctangent of 2^-i in accumulator units, where 2^31 is pi.
  localparam logic [31:0] ArctanTable [Steps] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };
  localparam logic [31:0] HalfTurn  = 32'h8000_0000;
  localparam logic [31:0] PhaseHalf = 32'h0000_8000;

  // Inverse of the CORDIC gain in Q0.32.
  localparam longint unsigned InvGain = 64'h0000_0000_9B74_EDA8;
  localparam int GainSplit = 21;
  localparam int MagShift  = 11 + FracBits;

  // The tail wait covers the pipeline latency with margin.
  localparam int TailCycles = 40;
  // The slowest legal run stays well below this even when every sample
  // meets the longest sender gap and the longest receiver stall.
  localparam int CycleLimit = 400_000;

  typedef struct {
    logic signed [Width-1:0] re;
    logic signed [Width-1:0] im;
    int unsigned             gap;    // idle cycles before this sample
    bit                      drain;  // hold until nothing is outstanding
  } sample_t;

  typedef struct {
    logic        [Width-1:0]      magnitude;
    logic signed [PhaseWidth-1:0] phase;
  } polar_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  c2p_cplx_if  #(.DataWidth(Width)) in_if ();
  c2p_polar_if #(.DataWidth(Width)) out_if ();

  cartesian_to_polar #(
    .DataWidth (Width),
    .AngleSteps(Steps)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sample_t     sample_q[$];
  polar_t      polar_expected_q[$];
  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;

  // Bit-exact expected result of one sample.
  function automatic polar_t polar_of(logic signed [Width-1:0] re,
                                      logic signed [Width-1:0] im);
    longint          x;
    longint          y;
    longint          x_shr;
    longint          y_shr;
    logic [31:0]     angle;
    longint unsigned x_pos;
    longint unsigned scaled;
    longint unsigned mag;
    polar_t          res;
    x = re;
    y = im;
    if (x == 0 && y == 0) begin
      res.magnitude = '0;
      res.phase     = '0;
      return res;
    end
    angle = '0;
    // Fold the left half plane over: negate both parts and start at pi.
    if (x < 0) begin
      x     = -x;
      y     = -y;
      angle = HalfTurn;
    end
    x = x * (64'sd1 <<< FracBits);
    y = y * (64'sd1 <<< FracBits);
    for (int i = 0; i < Steps; i++) begin
      x_shr = x >>> i;
      y_shr = y >>> i;
      // A zero imaginary part rotates clockwise, like a positive one.
      if (y >= 0) begin
        x     = x + y_shr;
        y     = y - x_shr;
        angle = angle + ArctanTable[i];
      end else begin
        x     = x - y_shr;
        y     = y + x_shr;
        angle = angle - ArctanTable[i];
      end
    end
    x_pos  = (x < 0) ? 64'd0 : longint'(x);
    // The gain product is split so that the low part keeps its fraction.
    scaled = (x_pos >> GainSplit) * InvGain
           + (((x_pos & ((64'd1 << GainSplit) - 1)) * InvGain) >> GainSplit);
    mag    = (scaled + (64'd1 << (MagShift - 1))) >> MagShift;
    if (mag > ((64'd1 << Width) - 1)) begin
      mag = (64'd1 << Width) - 1;
    end
    angle         = angle + PhaseHalf;
    res.magnitude = mag[Width-1:0];
    res.phase     = angle[31:16];
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_sample(input logic signed [Width-1:0] re,
                              input logic signed [Width-1:0] im,
                              input int unsigned gap, input bit drain);
    sample_t s;
    s.re    = re;
    s.im    = im;
    s.gap   = gap;
    s.drain = drain;
    sample_q.push_back(s);
    samples_queued++;
  endtask

  // Sender side. A transfer is recorded first; then, if the slot is free,
  // the next sample is presented after its gap. A sample marked for drain
  // waits until every outstanding result has come back. Valid gets one
  // nonblocking assignment per edge at most and stays up while ready is low.
  int unsigned send_hold = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.real_part <= '0;
      in_if.imag_part <= '0;
      send_hold = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        polar_expected_q.push_back(polar_of(in_if.real_part, in_if.imag_part));
        samples_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_hold > 0) begin
          send_hold--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (sample_q[0].drain && polar_expected_q.size() != 0) begin
          in_if.valid <= 1'b0;
        end else if (sample_q[0].gap > 0) begin
          send_hold = sample_q[0].gap - 1;
          sample_q[0].gap = 0;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid     <= 1'b1;
          in_if.real_part <= sample_q[0].re;
          in_if.imag_part <= sample_q[0].im;
          void'(sample_q.pop_front());
        end
      end
    end
  end

  // Receiver side. Every result transfer is checked against the oldest
  // outstanding result. Ready drops for random stalls, with occasional
  // long stretches where it stays high.
  int unsigned stall_left  = 0;
  int unsigned steady_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left  = 0;
      steady_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (polar_expected_q.size() == 0) begin
          $display("%0t: result with no sample outstanding: magnitude %0d phase %0d",
                   $time, out_if.magnitude, $signed(out_if.phase));
          mismatch_count++;
        end else begin
          if (out_if.magnitude !== polar_expected_q[0].magnitude) begin
            $display("%0t: magnitude mismatch, expected %0d actual %0d", $time,
                     polar_expected_q[0].magnitude, out_if.magnitude);
            mismatch_count++;
          end
          if (out_if.phase !== polar_expected_q[0].phase) begin
            $display("%0t: phase mismatch, expected %0d actual %0d", $time,
                     $signed(polar_expected_q[0].phase), $signed(out_if.phase));
            mismatch_count++;
          end
          void'(polar_expected_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          steady_left = $urandom_range(50, 150);
        end else begin
          stall_left = idle_len();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned             kind;
    int unsigned             gap;
    bit                      no_gaps;
    logic signed [Width-1:0] re;
    logic signed [Width-1:0] im;
    logic signed [Width-1:0] corner [6];

    rst_ni = 1'b0;
    corner = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};

    // Directed samples, back to back: the zero vector, the axis and corner
    // extremes (the largest magnitude is at -32768 - 32768j), the pi wrap
    // from the negative real axis, the zero imaginary part on both sides,
    // and unit steps in every direction.
    queue_sample(16'sd0, 16'sd0, 0, 1'b0);
    queue_sample(16'sh7FFF, 16'sd0, 0, 1'b0);
    queue_sample(16'sh8000, 16'sd0, 0, 1'b0);
    queue_sample(16'sd0, 16'sh7FFF, 0, 1'b0);
    queue_sample(16'sd0, 16'sh8000, 0, 1'b0);
    queue_sample(16'sh7FFF, 16'sh7FFF, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh8000, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh7FFF, 0, 1'b0);
    queue_sample(16'sh7FFF, 16'sh8000, 0, 1'b0);
    queue_sample(-16'sd1, 16'sd0, 0, 1'b0);
    queue_sample(16'sd1, 16'sd0, 0, 1'b0);
    queue_sample(16'sd0, 16'sd1, 0, 1'b0);
    queue_sample(16'sd0, -16'sd1, 0, 1'b0);
    queue_sample(-16'sd1, -16'sd1, 0, 1'b0);
    queue_sample(16'sd1, 16'sd1, 0, 1'b0);
    queue_sample(-16'sd1, 16'sd1, 0, 1'b0);
    queue_sample(16'sd1, -16'sd1, 0, 1'b0);
    queue_sample(-16'sd100, 16'sd0, 0, 1'b0);
    queue_sample(16'sd100, 16'sd0, 0, 1'b0);
    queue_sample(-16'sd20000, 16'sd3, 0, 1'b0);
    queue_sample(16'sd3, -16'sd20000, 0, 1'b0);
    queue_sample(16'sd12345, -16'sd23456, 0, 1'b0);

    // Random samples in bursts of 50; some bursts run with no sender gaps.
    // Every 200th sample first lets the pipeline empty completely.
    for (int n = 0; n < 650; n++) begin
      if (n % 50 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        re = Width'($urandom);
        im = Width'($urandom);
      end else if (kind < 65) begin
        re = Width'($signed($urandom_range(0, 32)) - 16);
        im = Width'($signed($urandom_range(0, 32)) - 16);
      end else if (kind < 75) begin
        re = Width'($urandom);
        case ($urandom_range(0, 3))
          0:       im = '0;
          1:       im = re;
          2:       im = -re;
          default: begin
            im = re;
            re = '0;
          end
        endcase
      end else if (kind < 85) begin
        re = corner[$urandom_range(0, 5)];
        im = corner[$urandom_range(0, 5)];
      end else begin
        // Near full scale with random low bits.
        re = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
        im = Width'($urandom);
      end
      gap = no_gaps ? 0 : idle_len();
      queue_sample(re, im, gap, (n % 200 == 0));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_accepted != samples_queued || polar_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/c2p_pkg.sv
sv/c2p_if.sv
sv/c2p_stage.sv
sv/cartesian_to_polar.sv
sv/c2p_checker.sv
test/testbench.sv
